// ===== rtl/wnsf_pkg.sv =====
// shared constants for the windowed noise sensor fusion core
`default_nettype none
package wnsf_pkg;
    localparam int WINDOW    = 10;
    localparam int FRAC_BITS = 16;
    localparam int NUM_CH    = 3;
    localparam int DATA_W    = 32;
    localparam int UNC_W     = 31;
    localparam int IDX_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W     = DATA_W + IDX_W;
    localparam int DIV_W     = 64;
    localparam int DEN_W     = 33;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);
    localparam int SQRT_STEPS = 32;
    localparam int SQRT_CNT_W = $clog2(SQRT_STEPS + 1);
    localparam int MUL_W     = 34;
    localparam int GAIN_W    = FRAC_BITS + 1;
    localparam int IN_TDATA_W  = 288;
    localparam int OUT_TDATA_W = 96;
    // divide by WINDOW as a multiply by a rounded-up reciprocal, exact for RCP_N bit dividends
    localparam int RCP_N     = 2*DATA_W - 1 - FRAC_BITS + IDX_W;
    localparam int RCP_K     = RCP_N + IDX_W;
    localparam int RCP_ACC_W = 2*RCP_N + 1;
    localparam logic [RCP_N:0] RCP_M =
        (RCP_N+1)'(((128'd1 << RCP_K) + 128'(WINDOW) - 128'd1) / 128'(WINDOW));
endpackage
`default_nettype wire

// ===== rtl/wnsf_mul.sv =====
// registered signed multiplier shared by squares, reciprocal divides, squared mean and gain product
`default_nettype none
module wnsf_mul (
    input  wire logic                                  clk,
    input  wire logic signed [wnsf_pkg::MUL_W-1:0]     a,
    input  wire logic signed [wnsf_pkg::MUL_W-1:0]     b,
    output logic signed [2*wnsf_pkg::MUL_W-1:0]        p
);
    import wnsf_pkg::*;

    logic signed [2*MUL_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;
endmodule
`default_nettype wire

// ===== rtl/wnsf_div.sv =====
// iterative restoring divider, one quotient bit per cycle
`default_nettype none
module wnsf_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [wnsf_pkg::DIV_W-1:0]    dividend,
    input  wire logic [wnsf_pkg::DEN_W-1:0]    divisor,
    output logic                               done,
    output logic [wnsf_pkg::DIV_W-1:0]         quotient
);
    import wnsf_pkg::*;

    logic [DEN_W-1:0]     den_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [DIV_W-1:0]     quo_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DEN_W:0]       rem_sh;
    logic                 fits;

    assign rem_sh = {rem_reg, quo_reg[DIV_W-1]};
    assign fits   = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= DIV_CNT_W'(DIV_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= DEN_W'(rem_sh - {1'b0, den_reg});
            end
            else
            begin
                rem_reg <= rem_sh[DEN_W-1:0];
            end
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule
`default_nettype wire

// ===== rtl/wnsf_sqrt.sv =====
// iterative integer square root, one root bit per cycle
`default_nettype none
module wnsf_sqrt (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [wnsf_pkg::DIV_W-1:0]    radicand,
    output logic                               done,
    output logic [wnsf_pkg::SQRT_STEPS-1:0]    root
);
    import wnsf_pkg::*;

    logic [DIV_W-1:0]      rad_reg;
    logic [SQRT_STEPS+1:0] rem_reg;
    logic [SQRT_STEPS-1:0] root_reg;
    logic [SQRT_CNT_W-1:0] cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [SQRT_STEPS+3:0] rem_sh;
    logic [SQRT_STEPS+1:0] trial;
    logic                  fits;

    assign rem_sh = {rem_reg, rad_reg[DIV_W-1:DIV_W-2]};
    assign trial  = {root_reg, 2'b01};
    assign fits   = rem_sh >= {2'b00, trial};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= SQRT_CNT_W'(SQRT_STEPS);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == SQRT_CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg <= {rad_reg[DIV_W-3:0], 2'b00};
            if (fits)
            begin
                rem_reg <= (SQRT_STEPS+2)'(rem_sh - {2'b00, trial});
            end
            else
            begin
                rem_reg <= rem_sh[SQRT_STEPS+1:0];
            end
            root_reg <= {root_reg[SQRT_STEPS-2:0], fits};
        end
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule
`default_nettype wire

// ===== rtl/windowed_noise_sensor_fusion_core.sv =====
// Windowed noise sensor fusion core.
// Input stream s_axis_*: one transaction carries three IMU samples, three odometry
// values and three odometry uncertainties. Output stream m_axis_*: one
// transaction per input with the three fused values.
// Each IMU sample enters a ring of WINDOW entries per channel. Per channel a
// small sequencer walks the ring through one registered multiplier for the
// sums, reuses that multiplier for the two divides by WINDOW (four partial
// products of a reciprocal each), then runs a 32-step square root unit for the
// deviation and one shared 64-step restoring divider for the gain.
// The gain divide dominates the work of each channel and is skipped when the gain
// denominator is zero. m_axis_tvalid rises once all three channels are fused, and
// the next item is accepted only after the previous one has left the sequencer.
// s_axis_tready is high only while the sequencer is idle, one item at a time.
// The result sits in an output register: a stalled receiver does not block
// the next input, but the sequencer waits at its end until the register is
// free. Reset clears the rings, the write slot and the output valid.
`default_nettype none
module windowed_noise_sensor_fusion_core (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // imu_accel_x, imu_accel_y, imu_gyro_z, odo_accel_x, odo_accel_y, odo_gyro_z,
    // odo_accel_x_uncert, odo_accel_y_uncert, odo_gyro_z_uncert, zero pad
    input  wire logic [wnsf_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // fused_accel_x, fused_accel_y, fused_gyro_z
    output logic [wnsf_pkg::OUT_TDATA_W-1:0]           m_axis_tdata
);
    import wnsf_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_ACC_RD, S_ACC_MUL, S_ACC_ADD, S_MSQ, S_RCP_OP, S_RCP_MUL, S_RCP_ADD,
        S_MEAN, S_M2_OP, S_M2_MUL, S_VAR, S_SQRT_W, S_GAIN, S_GAIN_W, S_FUSE_MUL,
        S_FUSE, S_DONE
    } state_t;

    state_t state_reg;

    logic signed [DATA_W-1:0] win_reg [NUM_CH][WINDOW];
    logic [IDX_W-1:0]         slot_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic [1:0]               ch_reg;

    logic signed [DATA_W-1:0] imu_reg [NUM_CH];
    logic signed [DATA_W-1:0] odo_reg [NUM_CH];
    logic [UNC_W-1:0]         unc_reg [NUM_CH];
    logic signed [DATA_W-1:0] fused_reg [NUM_CH];

    logic signed [SUM_W-1:0]  sum_reg;
    logic [DIV_W-1:0]         sumsq_reg;
    logic [DIV_W-1:0]         msq_reg;
    logic [DEN_W-1:0]         den_reg;

    logic [RCP_N-1:0]         rcp_n_reg;
    logic [RCP_ACC_W-1:0]     rcp_acc_reg;
    logic [1:0]               part_reg;
    logic                     rcp_mean_reg;
    logic [RCP_ACC_W-1:0]     rcp_term;

    logic signed [MUL_W-1:0]  mul_a_reg;
    logic signed [MUL_W-1:0]  mul_b_reg;
    logic signed [2*MUL_W-1:0] mul_p;

    logic                     div_start_reg;
    logic [DIV_W-1:0]         div_dividend_reg;
    logic [DEN_W-1:0]         div_divisor_reg;
    logic                     div_done;
    logic [DIV_W-1:0]         div_q;

    logic                     sqrt_start_reg;
    logic [DIV_W-1:0]         sqrt_rad_reg;
    logic                     sqrt_done;
    logic [SQRT_STEPS-1:0]    sqrt_root;

    logic                     out_valid_reg;
    logic [OUT_TDATA_W-1:0]   out_data_reg;

    logic signed [DATA_W-1:0] cur_x;
    logic signed [SUM_W-1:0]  abs_sum;
    logic [DIV_W-1:0]         mean2;
    logic [DIV_W-1:0]         var_w;
    logic signed [DATA_W:0]   diff;
    logic signed [2*MUL_W:0]  fused_w;
    logic signed [DATA_W-1:0] fused_sat;

    assign cur_x   = win_reg[ch_reg][idx_reg];
    assign abs_sum = (sum_reg < 0) ? -sum_reg : sum_reg;
    assign mean2   = mul_p[DIV_W-1:0] >> FRAC_BITS;
    assign var_w   = (msq_reg > mean2) ? (msq_reg - mean2) : '0;
    assign diff    = (DATA_W+1)'(imu_reg[ch_reg]) - (DATA_W+1)'(odo_reg[ch_reg]);
    // floor shift of the gain product, then add odo
    assign fused_w = (2*MUL_W+1)'(odo_reg[ch_reg]) + (2*MUL_W+1)'(mul_p >>> FRAC_BITS);

    // partial product of dividend and reciprocal, placed at its weight
    always_comb
    begin
        if (part_reg == 2'd0)
            rcp_term = RCP_ACC_W'(mul_p[2*DATA_W-1:0]);
        else if (part_reg inside {2'd1, 2'd2})
            rcp_term = RCP_ACC_W'(mul_p[2*DATA_W-1:0]) << DATA_W;
        else
            rcp_term = RCP_ACC_W'(mul_p[2*DATA_W-1:0]) << (2*DATA_W);
    end

    always_comb
    begin
        if (fused_w > (2*MUL_W+1)'(64'sd2147483647))
            fused_sat = 32'sh7fffffff;
        else if (fused_w < -(2*MUL_W+1)'(64'sd2147483648))
            fused_sat = 32'sh80000000;
        else
            fused_sat = fused_w[DATA_W-1:0];
    end

    wnsf_mul u_mul (
        .clk (clk),
        .a   (mul_a_reg),
        .b   (mul_b_reg),
        .p   (mul_p)
    );

    wnsf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (div_dividend_reg),
        .divisor  (div_divisor_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    wnsf_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start_reg),
        .radicand (sqrt_rad_reg),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            slot_reg       <= '0;
            idx_reg        <= '0;
            ch_reg         <= '0;
            div_start_reg  <= 1'b0;
            sqrt_start_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int c = 0; c < NUM_CH; c++)
            begin
                for (int i = 0; i < WINDOW; i++)
                begin
                    win_reg[c][i] <= '0;
                end
            end
        end
        else
        begin
            div_start_reg  <= (state_reg == S_GAIN) && (den_reg != '0);
            sqrt_start_reg <= (state_reg == S_VAR);
            if (m_axis_tready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        for (int c = 0; c < NUM_CH; c++)
                        begin
                            imu_reg[c] <= s_axis_tdata[c*DATA_W +: DATA_W];
                            odo_reg[c] <= s_axis_tdata[(c+NUM_CH)*DATA_W +: DATA_W];
                            unc_reg[c] <= s_axis_tdata[2*NUM_CH*DATA_W + c*UNC_W +: UNC_W];
                            win_reg[c][slot_reg] <= s_axis_tdata[c*DATA_W +: DATA_W];
                        end
                        slot_reg  <= (slot_reg == IDX_W'(WINDOW-1)) ? '0 : slot_reg + 1'b1;
                        ch_reg    <= '0;
                        idx_reg   <= '0;
                        sum_reg   <= '0;
                        sumsq_reg <= '0;
                        state_reg <= S_ACC_RD;
                    end
                end
                S_ACC_RD:
                begin
                    mul_a_reg <= MUL_W'(cur_x);
                    mul_b_reg <= MUL_W'(cur_x);
                    sum_reg   <= sum_reg + SUM_W'(cur_x);
                    state_reg <= S_ACC_MUL;
                end
                S_ACC_MUL:
                begin
                    state_reg <= S_ACC_ADD;
                end
                S_ACC_ADD:
                begin
                    sumsq_reg <= sumsq_reg + (mul_p[DIV_W-1:0] >> FRAC_BITS);
                    if (idx_reg == IDX_W'(WINDOW-1))
                    begin
                        state_reg <= S_MSQ;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_ACC_RD;
                    end
                end
                S_MSQ:
                begin
                    rcp_n_reg    <= RCP_N'(sumsq_reg);
                    rcp_acc_reg  <= '0;
                    part_reg     <= '0;
                    rcp_mean_reg <= 1'b0;
                    state_reg    <= S_RCP_OP;
                end
                S_RCP_OP:
                begin
                    mul_a_reg <= part_reg[1] ? MUL_W'(rcp_n_reg[RCP_N-1:DATA_W])
                                             : MUL_W'(rcp_n_reg[DATA_W-1:0]);
                    mul_b_reg <= part_reg[0] ? MUL_W'(RCP_M[RCP_N:DATA_W])
                                             : MUL_W'(RCP_M[DATA_W-1:0]);
                    state_reg <= S_RCP_MUL;
                end
                S_RCP_MUL:
                begin
                    state_reg <= S_RCP_ADD;
                end
                S_RCP_ADD:
                begin
                    rcp_acc_reg <= rcp_acc_reg + rcp_term;
                    if (part_reg == 2'd3)
                    begin
                        state_reg <= rcp_mean_reg ? S_M2_OP : S_MEAN;
                    end
                    else
                    begin
                        part_reg  <= part_reg + 1'b1;
                        state_reg <= S_RCP_OP;
                    end
                end
                S_MEAN:
                begin
                    msq_reg      <= DIV_W'(rcp_acc_reg >> RCP_K);
                    rcp_n_reg    <= RCP_N'(unsigned'(abs_sum));
                    rcp_acc_reg  <= '0;
                    part_reg     <= '0;
                    rcp_mean_reg <= 1'b1;
                    state_reg    <= S_RCP_OP;
                end
                S_M2_OP:
                begin
                    mul_a_reg <= MUL_W'(rcp_acc_reg[RCP_K +: DATA_W]);
                    mul_b_reg <= MUL_W'(rcp_acc_reg[RCP_K +: DATA_W]);
                    state_reg <= S_M2_MUL;
                end
                S_M2_MUL:
                begin
                    state_reg <= S_VAR;
                end
                S_VAR:
                begin
                    sqrt_rad_reg <= var_w << FRAC_BITS;
                    state_reg    <= S_SQRT_W;
                end
                S_SQRT_W:
                begin
                    if (sqrt_done)
                    begin
                        den_reg   <= DEN_W'(unc_reg[ch_reg]) + DEN_W'(sqrt_root);
                        state_reg <= S_GAIN;
                    end
                end
                S_GAIN:
                begin
                    if (den_reg == '0)
                    begin
                        mul_a_reg <= '0;
                        mul_b_reg <= MUL_W'(diff);
                        state_reg <= S_FUSE_MUL;
                    end
                    else
                    begin
                        div_dividend_reg <= DIV_W'(unc_reg[ch_reg]) << FRAC_BITS;
                        div_divisor_reg  <= den_reg;
                        state_reg        <= S_GAIN_W;
                    end
                end
                S_GAIN_W:
                begin
                    if (div_done)
                    begin
                        mul_a_reg <= MUL_W'({1'b0, div_q[GAIN_W-1:0]});
                        mul_b_reg <= MUL_W'(diff);
                        state_reg <= S_FUSE_MUL;
                    end
                end
                S_FUSE_MUL:
                begin
                    state_reg <= S_FUSE;
                end
                S_FUSE:
                begin
                    fused_reg[ch_reg] <= fused_sat;
                    if (ch_reg == 2'(NUM_CH-1))
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        ch_reg    <= ch_reg + 1'b1;
                        idx_reg   <= '0;
                        sum_reg   <= '0;
                        sumsq_reg <= '0;
                        state_reg <= S_ACC_RD;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {fused_reg[2], fused_reg[1], fused_reg[0]};
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
endmodule
`default_nettype wire
